FILE: src/sopag_pkg.sv
// Shared types and constants for the sum-of-pairs affine gap scorer.
// No dependencies; imported by sum_of_pairs_affine_gap_score and tb_top.

package sopag_pkg;

    // Defaults for the top-level parameters.
    localparam int CLASS_COUNT_DEF = 32;
    localparam int SCORE_BITS_DEF  = 16;
    localparam int RUN_BITS_DEF    = 16;

    // Fixed field widths.
    localparam int SYM_W     = 8;
    localparam int LOAD_W    = 16;
    localparam int TOTAL_W   = 40;
    localparam int GAP_OUT_W = 16;
    localparam int PEN_REG_W = 15;
    localparam int CFG_IDX_W = 1;
    localparam int MAP_DEPTH = 256;

    localparam logic [SYM_W-1:0] GAP_CODE = 8'd45;

    localparam logic [PEN_REG_W-1:0] GAP_OPEN_RST   = 15'd160;
    localparam logic [PEN_REG_W-1:0] GAP_EXTEND_RST = 15'd16;

    localparam longint TOTAL_MAX = 64'sd549755813887;
    localparam longint TOTAL_MIN = -64'sd549755813888;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_EXTEND = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD_MAP   = 2'd0,
        CMD_LOAD_SCORE = 2'd1,
        CMD_SCORE_COL  = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

endpackage

FILE: src/sum_of_pairs_affine_gap_score.sv
// Sum-of-pairs alignment scorer with affine gap penalties: class map and
// substitution table memories, gap run and saturating total.
// Depends on sopag_pkg.
//
// Throughput: one item per cycle while m_tready does not stall the pipeline;
// the class map read, the table read and the penalty multiply-accumulate
// each take one register stage.
// Reset clears the stage valids, the gap run and the total, and loads the
// gap penalties with their defaults; the map and table memories keep their
// contents and must be loaded before use.

module sum_of_pairs_affine_gap_score
    import sopag_pkg::*;
#(
    parameter int CLASS_COUNT = CLASS_COUNT_DEF,
    parameter int SCORE_BITS  = SCORE_BITS_DEF,
    parameter int RUN_BITS    = RUN_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PEN_REG_W-1:0] cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // sym_a[7:0], sym_b[15:8], load_value[31:16]
    input  logic [1:0]           s_tuser,   // cmd[1:0]
    input  logic                 s_tlast,   // last_in_pair

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // total_score[39:0], gap_run[55:40]
    output logic                 m_tlast    // pair_closed
);

    localparam int CB        = $clog2(CLASS_COUNT);
    localparam int TAB_DEPTH = CLASS_COUNT * CLASS_COUNT;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int PEN_W     = PEN_REG_W + RUN_BITS + 1;
    localparam int SUM_W     = ((PEN_W > TOTAL_W) ? PEN_W : TOTAL_W) + 2;
    localparam int GW        = (RUN_BITS > GAP_OUT_W) ? RUN_BITS : GAP_OUT_W;

    localparam logic signed [32:0] SCORE_MAX = 33'sd1 <<< (SCORE_BITS - 1);
    localparam logic signed [32:0] SMAX      = SCORE_MAX - 33'sd1;
    localparam logic signed [32:0] SMIN      = -SCORE_MAX;
    localparam logic signed [SUM_W-1:0] T_MAX = SUM_W'(TOTAL_MAX);
    localparam logic signed [SUM_W-1:0] T_MIN = SUM_W'(TOTAL_MIN);
    localparam logic signed [LOAD_W-1:0] CLASS_TOP = LOAD_W'(CLASS_COUNT - 1);
    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

    // Configuration registers.
    logic [PEN_REG_W-1:0] gap_open_reg;
    logic [PEN_REG_W-1:0] gap_extend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_open_reg   <= GAP_OPEN_RST;
            gap_extend_reg <= GAP_EXTEND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAP_OPEN:   gap_open_reg   <= cfg_data;
                REG_GAP_EXTEND: gap_extend_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Stage enables; a stage takes new data when it is empty or drains.
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    logic                     in_xfer;
    cmd_t                     in_cmd;
    logic [SYM_W-1:0]         in_a;
    logic [SYM_W-1:0]         in_b;
    logic signed [LOAD_W-1:0] in_lv;
    logic [CB-1:0]            in_class;

    assign in_xfer = s_tvalid && s_tready;
    assign in_cmd  = cmd_t'(s_tuser);
    assign in_a    = s_tdata[7:0];
    assign in_b    = s_tdata[15:8];
    assign in_lv   = $signed(s_tdata[31:16]);

    always_comb
    begin
        if (in_lv < 0)
            in_class = '0;
        else if (in_lv > CLASS_TOP)
            in_class = CB'(CLASS_COUNT - 1);
        else
            in_class = in_lv[CB-1:0];
    end

    // Class map: written by a map load on transfer, read for both symbols.
    logic [CB-1:0] cmap_mem [MAP_DEPTH];
    logic [CB-1:0] ca1_reg;
    logic [CB-1:0] cb1_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_cmd == CMD_LOAD_MAP)
            cmap_mem[in_a] <= in_class;
        if (en1)
        begin
            ca1_reg <= cmap_mem[in_a];
            cb1_reg <= cmap_mem[in_b];
        end
    end

    // Stage 1 item register.
    cmd_t                     cmd1_reg;
    logic [SYM_W-1:0]         a1_reg;
    logic [SYM_W-1:0]         b1_reg;
    logic                     last1_reg;
    logic signed [LOAD_W-1:0] lv1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            cmd1_reg <= CMD_LOAD_MAP;
        end
        else if (en1)
        begin
            v1_reg   <= in_xfer;
            cmd1_reg <= in_cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            a1_reg    <= in_a;
            b1_reg    <= in_b;
            last1_reg <= s_tlast;
            lv1_reg   <= in_lv;
        end
    end

    // Stage 1 logic: table addresses and score saturation.
    logic                    tab_we;
    logic [TAB_AW:0]         wr_idx;
    logic [TAB_AW:0]         rd_idx;
    logic [TAB_AW-1:0]       tab_raddr;
    logic signed [32:0]      lv_wide;
    logic [SCORE_BITS-1:0]   tab_wdata;

    assign wr_idx = (TAB_AW+1)'(a1_reg) * (TAB_AW+1)'(CLASS_COUNT) + (TAB_AW+1)'(b1_reg);
    assign rd_idx = (TAB_AW+1)'(ca1_reg) * (TAB_AW+1)'(CLASS_COUNT) + (TAB_AW+1)'(cb1_reg);
    assign tab_we = en2 && v1_reg && cmd1_reg == CMD_LOAD_SCORE
                    && a1_reg < CLASS_COUNT && b1_reg < CLASS_COUNT;
    // A class outside the table only comes from an unloaded map entry.
    assign tab_raddr = (rd_idx < TAB_DEPTH) ? rd_idx[TAB_AW-1:0] : '0;
    assign lv_wide   = 33'(lv1_reg);

    always_comb
    begin
        if (lv_wide > SMAX)
            tab_wdata = SMAX[SCORE_BITS-1:0];
        else if (lv_wide < SMIN)
            tab_wdata = SMIN[SCORE_BITS-1:0];
        else
            tab_wdata = lv_wide[SCORE_BITS-1:0];
    end

    logic [SCORE_BITS-1:0] tab_mem [TAB_DEPTH];
    logic [SCORE_BITS-1:0] score2_reg;

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[wr_idx[TAB_AW-1:0]] <= tab_wdata;
        if (en2)
            score2_reg <= tab_mem[tab_raddr];
    end

    // Stage 2 item register.
    cmd_t cmd2_reg;
    logic ga2_reg;
    logic gb2_reg;
    logic last2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg   <= 1'b0;
            cmd2_reg <= CMD_LOAD_MAP;
        end
        else if (en2)
        begin
            v2_reg   <= v1_reg;
            cmd2_reg <= cmd1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            ga2_reg   <= (a1_reg == GAP_CODE);
            gb2_reg   <= (b1_reg == GAP_CODE);
            last2_reg <= last1_reg;
        end
    end

    // Stage 2 logic: gap run and total update. The run is charged at most
    // once per column, with the run length after this column's own gap.
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [TOTAL_W-1:0] total_next;
    logic [RUN_BITS-1:0]       gap_reg;
    logic [RUN_BITS-1:0]       gap_next;
    logic                      closed_reg;
    logic                      closed_next;

    logic                      residue;
    logic                      one_gap;
    logic [RUN_BITS-1:0]       cnt_inc;
    logic [RUN_BITS-1:0]       cnt_eff;
    logic                      charge;
    logic [PEN_W-1:0]          pen;
    logic signed [SUM_W-1:0]   add_term;
    logic signed [SUM_W-1:0]   pen_term;
    logic signed [SUM_W-1:0]   sum;
    logic signed [TOTAL_W-1:0] sum_sat;

    assign residue  = !ga2_reg && !gb2_reg;
    assign one_gap  = ga2_reg ^ gb2_reg;
    assign cnt_inc  = (gap_reg != RUN_MAX) ? gap_reg + RUN_BITS'(1) : gap_reg;
    assign cnt_eff  = one_gap ? cnt_inc : gap_reg;
    assign charge   = (cnt_eff != '0) && (residue || last2_reg);
    assign pen      = PEN_W'(gap_open_reg) + PEN_W'(gap_extend_reg) * PEN_W'(cnt_eff);
    assign add_term = residue ? SUM_W'($signed(score2_reg)) : '0;
    assign pen_term = charge ? $signed(SUM_W'(pen)) : '0;
    assign sum      = SUM_W'(total_reg) + add_term - pen_term;

    always_comb
    begin
        if (sum > T_MAX)
            sum_sat = T_MAX[TOTAL_W-1:0];
        else if (sum < T_MIN)
            sum_sat = T_MIN[TOTAL_W-1:0];
        else
            sum_sat = sum[TOTAL_W-1:0];
    end

    always_comb
    begin
        total_next  = total_reg;
        gap_next    = gap_reg;
        closed_next = 1'b0;
        unique case (cmd2_reg)
            CMD_SCORE_COL:
            begin
                total_next  = sum_sat;
                gap_next    = (residue || last2_reg) ? '0 : cnt_eff;
                closed_next = last2_reg;
            end
            CMD_CLEAR:
                total_next = '0;
            CMD_LOAD_MAP, CMD_LOAD_SCORE:
                ;
        endcase
    end

    // Result register; the total and run double as the block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg     <= 1'b0;
            total_reg  <= '0;
            gap_reg    <= '0;
            closed_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
            if (v2_reg)
            begin
                total_reg  <= total_next;
                gap_reg    <= gap_next;
                closed_reg <= closed_next;
            end
        end
    end

    logic [GW-1:0] gap_wide;

    assign gap_wide = GW'(gap_reg);
    assign m_tvalid = v3_reg;
    assign m_tdata  = {gap_wide[GAP_OUT_W-1:0], total_reg};
    assign m_tlast  = closed_reg;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for sum_of_pairs_affine_gap_score: stimulus table rows, some with their
// own results, then random column streams under several gap penalty settings and a long
// gap run, the rest checked by a behavioral predictor. Depends on sopag_pkg and the scorer.

module tb_top;
    import sopag_pkg::*;

    localparam int N_CLASS          = CLASS_COUNT_DEF;
    localparam int CLS_W            = $clog2(CLASS_COUNT_DEF);
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 85;
    localparam int LONG_RUN_COLS    = 40;

    typedef struct packed {
        logic [TOTAL_W-1:0]   total;
        logic [GAP_OUT_W-1:0] run;
        logic                 closed;
    } score_res_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [SYM_W-1:0]  a;
        logic [SYM_W-1:0]  b;
        logic              last;
        logic [LOAD_W-1:0] lv;
        logic              typed;
        score_res_t        want;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PEN_REG_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // sym_a[7:0], sym_b[15:8], load_value[31:16]
    logic [1:0]           s_tuser   = '0;   // cmd[1:0]
    logic                 s_tlast   = 1'b0; // last_in_pair
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;          // total_score[39:0], gap_run[55:40]
    logic                 m_tlast;          // pair_closed

    sum_of_pairs_affine_gap_score dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: a shadow of the scorer's memories, run, total and penalties.
    logic [CLS_W-1:0]         sym_class [MAP_DEPTH];
    bit                       sym_mapped [MAP_DEPTH];
    logic [SYM_W-1:0]         mapped_syms [$];
    logic signed [LOAD_W-1:0] sub_score [N_CLASS*N_CLASS];
    bit                       sub_loaded [N_CLASS*N_CLASS];
    logic [GAP_OUT_W-1:0]     open_run   = '0;
    longint                   total_acc  = 0;
    logic [PEN_REG_W-1:0]     pen_open   = GAP_OPEN_RST;
    logic [PEN_REG_W-1:0]     pen_extend = GAP_EXTEND_RST;
    score_res_t               expected_scores [$];

    int mismatch_count = 0;
    int burst_left     = 0;
    bit tx_on          = 1'b0;
    int rx_mode        = 0;
    int rx_left        = 0;
    int rx_tick        = 0;
    int quiet_cycles   = 0;

    stim_row_t directed_rows [26] = '{
        '{CMD_CLEAR,      8'd0,   8'd0,   1'b1, 16'd0,    1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_MAP,   8'd65,  8'd0,   1'b0, 16'd3,    1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_MAP,   8'd255, 8'd0,   1'b0, 16'h8000, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_MAP,   8'd0,   8'd255, 1'b0, 16'h7FFF, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_MAP,   8'd67,  8'd0,   1'b0, 16'd32,   1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_MAP,   8'd128, 8'd0,   1'b1, 16'hFFFF, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_SCORE, 8'd3,   8'd3,   1'b0, 16'd80,   1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_SCORE, 8'd0,   8'd31,  1'b0, 16'h8000, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_SCORE, 8'd31,  8'd0,   1'b0, 16'h7FFF, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_SCORE, 8'd31,  8'd31,  1'b0, 16'hFFF0, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_SCORE, 8'd32,  8'd3,   1'b0, 16'd1000, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_SCORE, 8'd3,   8'd255, 1'b0, 16'hFC18, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_LOAD_SCORE, 8'd0,   8'd0,   1'b1, 16'd48,   1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_SCORE_COL,  8'd65,  8'd65,  1'b0, 16'd0,    1'b1, '{40'd80, 16'd0, 1'b0}},
        '{CMD_SCORE_COL,  8'd45,  8'd45,  1'b0, 16'hFFFF, 1'b1, '{40'd80, 16'd0, 1'b0}},
        '{CMD_SCORE_COL,  8'd45,  8'd65,  1'b0, 16'd0,    1'b1, '{40'd80, 16'd1, 1'b0}},
        '{CMD_SCORE_COL,  8'd200, 8'd45,  1'b0, 16'd0,    1'b1, '{40'd80, 16'd2, 1'b0}},
        '{CMD_SCORE_COL,  8'd255, 8'd0,   1'b0, 16'd0,    1'b0, '{40'd0,  16'd0, 1'b0}},
        '{CMD_SCORE_COL,  8'd45,  8'd1,   1'b1, 16'd0,    1'b0, '{40'd0,  16'd0, 1'b0}},
        '{CMD_SCORE_COL,  8'd0,   8'd255, 1'b1, 16'd0,    1'b0, '{40'd0,  16'd0, 1'b0}},
        '{CMD_SCORE_COL,  8'd45,  8'd45,  1'b1, 16'd0,    1'b0, '{40'd0,  16'd0, 1'b0}},
        '{CMD_SCORE_COL,  8'd128, 8'd255, 1'b0, 16'd0,    1'b0, '{40'd0,  16'd0, 1'b0}},
        '{CMD_CLEAR,      8'd255, 8'd255, 1'b1, 16'hFFFF, 1'b1, '{40'd0,  16'd0, 1'b0}},
        '{CMD_SCORE_COL,  8'd45,  8'd0,   1'b0, 16'd0,    1'b1, '{40'd0,  16'd1, 1'b0}},
        '{CMD_CLEAR,      8'd0,   8'd0,   1'b0, 16'd0,    1'b1, '{40'd0,  16'd1, 1'b0}},
        '{CMD_SCORE_COL,  8'd67,  8'd0,   1'b1, 16'd0,    1'b0, '{40'd0,  16'd0, 1'b0}}
    };

    function automatic longint clamp_total(longint v);
        if (v > TOTAL_MAX)
            return TOTAL_MAX;
        if (v < TOTAL_MIN)
            return TOTAL_MIN;
        return v;
    endfunction

    function automatic longint gap_charge();
        return longint'(pen_open) + longint'(pen_extend) * longint'(open_run);
    endfunction

    function automatic score_res_t predict_score(input cmd_t c, input logic [SYM_W-1:0] a,
                                                 input logic [SYM_W-1:0] b, input logic last,
                                                 input logic signed [LOAD_W-1:0] lv);
        score_res_t r;
        longint     delta;
        r.closed = 1'b0;
        case (c)
            CMD_LOAD_MAP:
            begin
                if (lv < 0)
                    sym_class[a] = '0;
                else if (lv > N_CLASS - 1)
                    sym_class[a] = CLS_W'(N_CLASS - 1);
                else
                    sym_class[a] = lv[CLS_W-1:0];
                if (!sym_mapped[a])
                begin
                    sym_mapped[a] = 1'b1;
                    mapped_syms = {mapped_syms, a};
                end
            end
            CMD_LOAD_SCORE:
            begin
                if (a < N_CLASS && b < N_CLASS)
                begin
                    sub_score[int'(a) * N_CLASS + int'(b)]  = lv;
                    sub_loaded[int'(a) * N_CLASS + int'(b)] = 1'b1;
                end
            end
            CMD_SCORE_COL:
            begin
                if (a != GAP_CODE && b != GAP_CODE)
                begin
                    delta = longint'(sub_score[int'(sym_class[a]) * N_CLASS
                                               + int'(sym_class[b])]);
                    if (open_run != 0)
                    begin
                        delta -= gap_charge();
                        open_run = '0;
                    end
                    total_acc = clamp_total(total_acc + delta);
                end
                // Exactly one side is a gap when the codes differ; a gap-gap column is skipped.
                else if (a != b)
                begin
                    if (open_run != '1)
                        open_run++;
                end
                if (last)
                begin
                    if (open_run != 0)
                    begin
                        total_acc = clamp_total(total_acc - gap_charge());
                        open_run  = '0;
                    end
                    r.closed = 1'b1;
                end
            end
            default:
                total_acc = 0;
        endcase
        r.total = total_acc[TOTAL_W-1:0];
        r.run   = open_run;
        return r;
    endfunction

    // Presents one item and blocks until its transfer. The sender runs in bursts with
    // random gaps in between; valid is only lowered when a gap actually follows.
    task automatic send_item(input cmd_t c, input logic [SYM_W-1:0] a,
                             input logic [SYM_W-1:0] b, input logic last,
                             input logic signed [LOAD_W-1:0] lv,
                             input logic typed, input score_res_t want);
        int         gap;
        score_res_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                if (tx_on)
                    s_tvalid <= 1'b0;
                tx_on = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lv, b, a};
        s_tuser  <= c;
        s_tlast  <= last;
        tx_on = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        res = predict_score(c, a, b, last, lv);
        expected_scores = {expected_scores, (typed ? want : res)};
    endtask

    // Stops the sender and waits until the scorer has returned everything it owes.
    task automatic drain_results();
        if (tx_on)
            s_tvalid <= 1'b0;
        tx_on = 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_penalties(input logic [PEN_REG_W-1:0] op, input logic [PEN_REG_W-1:0] ext);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAP_OPEN;
        cfg_data  <= op;
        @(posedge clk);
        cfg_index <= REG_GAP_EXTEND;
        cfg_data  <= ext;
        @(posedge clk);
        cfg_we <= 1'b0;
        pen_open   = op;
        pen_extend = ext;
    endtask

    // Mostly column streams grouped into pairs by the last flag, with loads and clears
    // mixed in. Residue columns only use mapped symbols, and a missing class pair is
    // loaded just before the column that needs it.
    task automatic random_item();
        int               pick;
        int               idx;
        logic [SYM_W-1:0] a;
        logic [SYM_W-1:0] b;
        logic             last;
        logic [LOAD_W-1:0] lv;
        pick = $urandom_range(0, 99);
        last = ($urandom_range(0, 7) == 0);
        lv   = LOAD_W'($urandom);
        a    = SYM_W'($urandom);
        b    = SYM_W'($urandom);
        if (pick < 8)
        begin
            if ($urandom_range(0, 3) != 0)
                lv = LOAD_W'($urandom_range(0, N_CLASS - 1));
            send_item(CMD_LOAD_MAP, a, b, last, lv, 1'b0, '0);
        end
        else if (pick < 16)
        begin
            if ($urandom_range(0, 7) != 0)
                a = SYM_W'($urandom_range(0, N_CLASS - 1));
            if ($urandom_range(0, 7) != 0)
                b = SYM_W'($urandom_range(0, N_CLASS - 1));
            send_item(CMD_LOAD_SCORE, a, b, last, lv, 1'b0, '0);
        end
        else if (pick < 19)
            send_item(CMD_CLEAR, a, b, last, lv, 1'b0, '0);
        else if (pick < 57)
        begin
            a = mapped_syms[$urandom_range(0, mapped_syms.size() - 1)];
            b = mapped_syms[$urandom_range(0, mapped_syms.size() - 1)];
            if (a != GAP_CODE && b != GAP_CODE)
            begin
                idx = int'(sym_class[a]) * N_CLASS + int'(sym_class[b]);
                if (!sub_loaded[idx])
                    send_item(CMD_LOAD_SCORE, SYM_W'(sym_class[a]), SYM_W'(sym_class[b]),
                              1'b0, LOAD_W'($urandom), 1'b0, '0);
            end
            send_item(CMD_SCORE_COL, a, b, last, lv, 1'b0, '0);
        end
        else if (pick < 93)
        begin
            if ($urandom_range(0, 1) == 0)
                a = GAP_CODE;
            else
                b = GAP_CODE;
            send_item(CMD_SCORE_COL, a, b, last, lv, 1'b0, '0);
        end
        else
            send_item(CMD_SCORE_COL, GAP_CODE, GAP_CODE, last, lv, 1'b0, '0);
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        score_res_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_scores.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, total_score %0d",
                         $time, $signed(m_tdata[TOTAL_W-1:0]));
                mismatch_count++;
            end
            else
            begin
                want = expected_scores.pop_front();
                if (m_tdata[TOTAL_W-1:0] !== want.total)
                begin
                    $display("%0t: total_score expected %0d actual %0d", $time,
                             $signed(want.total), $signed(m_tdata[TOTAL_W-1:0]));
                    mismatch_count++;
                end
                if (m_tdata[TOTAL_W +: GAP_OUT_W] !== want.run)
                begin
                    $display("%0t: gap_run expected %0d actual %0d", $time,
                             want.run, m_tdata[TOTAL_W +: GAP_OUT_W]);
                    mismatch_count++;
                end
                if (m_tlast !== want.closed)
                begin
                    $display("%0t: pair_closed expected %0b actual %0b", $time,
                             want.closed, m_tlast);
                    mismatch_count++;
                end
            end
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom);
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rx_tick % 5 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [SYM_W-1:0] other;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run with the reset penalties.
        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].last, directed_rows[i].lv,
                      directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       set_penalties('0, '0);
                1:       set_penalties('1, '1);
                2:       set_penalties(PEN_REG_W'($urandom), PEN_REG_W'($urandom));
                3:       set_penalties('1, '0);
                default: set_penalties(PEN_REG_W'($urandom_range(0, 255)),
                                       PEN_REG_W'($urandom_range(0, 64)));
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                random_item();
                if (p == 2 && n == RANDOM_PER_PHASE / 2)
                    drain_results();
            end
            drain_results();
        end

        // One long gap run, charged at the largest penalties.
        set_penalties('1, '1);
        for (int k = 0; k < LONG_RUN_COLS; k++)
        begin
            other = SYM_W'($urandom);
            if (k % 2 == 0)
                send_item(CMD_SCORE_COL, GAP_CODE, other, 1'b0, LOAD_W'($urandom), 1'b0, '0);
            else
                send_item(CMD_SCORE_COL, other, GAP_CODE, 1'b0, LOAD_W'($urandom), 1'b0, '0);
        end
        send_item(CMD_SCORE_COL, GAP_CODE, 8'd7, 1'b1, '0, 1'b0, '0);
        repeat (20) random_item();
        drain_results();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
src/sopag_pkg.sv
src/sum_of_pairs_affine_gap_score.sv
bench/tb_top.sv
